// ===== rtl/bbc_pkg.sv =====
// ----------------------------------------------------------------------------
// Bracket balance checker package
// Shared types, constants and symbol decode functions for the checker.
// ----------------------------------------------------------------------------
`default_nettype none

package bbc_pkg;

   // Stack sizing. The depth counter must be able to hold MAX_NESTING itself.
   localparam int MAX_NESTING = 64;
   localparam int DEPTH_W     = $clog2(MAX_NESTING + 1);
   localparam int ADDR_W      = $clog2(MAX_NESTING);

   // Bracket kinds as stored on the stack.
   typedef logic [1:0] kind_type;
   localparam kind_type KIND_ROUND  = 2'd0;
   localparam kind_type KIND_SQUARE = 2'd1;
   localparam kind_type KIND_CURLY  = 2'd2;
   localparam kind_type KIND_NONE   = 2'd3;

   // Error codes carried in the response.
   typedef logic [2:0] err_type;
   localparam err_type ERR_NONE     = 3'd0;
   localparam err_type ERR_MISMATCH = 3'd1;
   localparam err_type ERR_EMPTY    = 3'd2;
   localparam err_type ERR_UNCLOSED = 3'd3;
   localparam err_type ERR_OVERFLOW = 3'd4;

   // ASCII codes of the bracket characters.
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;

   // Request payload: one byte of the expression plus the end mark.
   typedef struct packed {
      logic [7:0] symbol;
      logic       last_symbol;
   } req_type;

   // Response payload: one per expression.
   typedef struct packed {
      logic       balanced;
      logic [2:0] error_code;
   } rsp_type;

   // Checker state as seen from the top level.
   typedef struct packed {
      logic [DEPTH_W-1:0] depth;
      err_type            err;
   } chk_status_type;

   // Kind of an opening bracket, or KIND_NONE.
   function automatic kind_type opener_kind(input logic [7:0] c);
      kind_type k;
      case (c)
         CH_LPAREN: k = KIND_ROUND;
         CH_LBRACK: k = KIND_SQUARE;
         CH_LBRACE: k = KIND_CURLY;
         default:   k = KIND_NONE;
      endcase
      return k;
   endfunction

   // Kind of a closing bracket, or KIND_NONE.
   function automatic kind_type closer_kind(input logic [7:0] c);
      kind_type k;
      case (c)
         CH_RPAREN: k = KIND_ROUND;
         CH_RBRACK: k = KIND_SQUARE;
         CH_RBRACE: k = KIND_CURLY;
         default:   k = KIND_NONE;
      endcase
      return k;
   endfunction

endpackage : bbc_pkg

`default_nettype wire

// ===== rtl/bbc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-write RAM
// One write port and one read port with a registered read data output.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule : bbc_ram

`default_nettype wire

// ===== rtl/bbc_checker.sv =====
// ----------------------------------------------------------------------------
// Bracket stack checker
// Holds the bracket stack, its depth and the sticky error, and forms the
// response for the request currently in the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_checker (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    advance,
   input  wire bbc_pkg::req_type        item,
   output      bbc_pkg::rsp_type        result,
   output      bbc_pkg::chk_status_type status
);

   import bbc_pkg::*;

   // The top entry lives in a register. The RAM holds every pushed entry and
   // is always reading the entry just below the top of the next cycle, so a
   // pop finds its new top waiting at the RAM output.
   logic [DEPTH_W-1:0] depth_ff,  depth_in,  depth_upd;
   err_type            err_ff,    err_in,    err_upd;
   kind_type           top_ff,    top_in;
   kind_type           open_k, close_k;
   kind_type           below_top;
   logic               wr_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [DEPTH_W-1:0] rd_depth;
   err_type            code;

   assign open_k  = opener_kind(item.symbol);
   assign close_k = closer_kind(item.symbol);

   // Push, pop or error for the current byte.
   always_comb begin
      depth_upd = depth_ff;
      err_upd   = err_ff;
      top_in    = top_ff;
      wr_en     = 1'b0;
      if (advance && (err_ff == ERR_NONE)) begin
         if (open_k != KIND_NONE) begin
            if (depth_ff == DEPTH_W'(MAX_NESTING)) begin
               err_upd = ERR_OVERFLOW;
            end else begin
               wr_en     = 1'b1;
               top_in    = open_k;
               depth_upd = depth_ff + DEPTH_W'(1);
            end
         end else if (close_k != KIND_NONE) begin
            if (depth_ff == '0) begin
               err_upd = ERR_EMPTY;
            end else if (top_ff != close_k) begin
               err_upd = ERR_MISMATCH;
            end else begin
               top_in    = below_top;
               depth_upd = depth_ff - DEPTH_W'(1);
            end
         end
      end
   end

   // Response after the byte is handled; open brackets left count as unclosed.
   always_comb begin
      code = err_upd;
      if ((err_upd == ERR_NONE) && (depth_upd != '0)) begin
         code = ERR_UNCLOSED;
      end
      result.balanced   = (code == ERR_NONE);
      result.error_code = code;
   end

   // The end of an expression clears the stack and the error.
   always_comb begin
      depth_in = depth_upd;
      err_in   = err_upd;
      if (advance && item.last_symbol) begin
         depth_in = '0;
         err_in   = ERR_NONE;
      end
   end

   // Read the entry two below the next depth; it is unused when shallower.
   assign rd_depth = depth_in - DEPTH_W'(2);
   assign rd_addr  = rd_depth[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
         err_ff   <= ERR_NONE;
      end else begin
         depth_ff <= depth_in;
         err_ff   <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
   end

   bbc_ram #(
      .WIDTH ($bits(kind_type)),
      .DEPTH (MAX_NESTING)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (depth_ff[ADDR_W-1:0]),
      .wr_data (open_k),
      .rd_addr (rd_addr),
      .rd_data (below_top)
   );

   assign status.depth = depth_ff;
   assign status.err   = err_ff;

endmodule : bbc_checker

`default_nettype wire

// ===== rtl/bracket_balance_checker_core.sv =====
// ----------------------------------------------------------------------------
// Bracket balance checker core
// Streams an expression one byte per request and reports once per
// expression whether its round, square and curly brackets balance.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the req_ channel carries one byte of text and a mark
//   for the final byte. Openers push onto a stack of MAX_NESTING entries,
//   matching closers pop it. The first error of an expression is kept.
//   The final byte of an expression produces one response on the rsp_
//   channel with a balanced flag and an error code; other bytes produce
//   none. The stack and error then clear for the next expression.
//   A request is registered in the input register and handled there; its
//   response is registered in the output register. Throughput: one
//   request per cycle unless a final byte stalls, set by one push or pop
//   on the stack RAM each cycle; the RAM pre-reads the entry under the top.
//   A stalled response holds in the output register. Bytes that are not
//   final keep flowing; a final byte waits in the input register until the
//   output register is free, which then holds off further requests.
//   Reset clears the stack depth, the error and both valid flags. The stack
//   RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module bracket_balance_checker_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_ready,
   input  wire bbc_pkg::req_type req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   output      bbc_pkg::rsp_type rsp_data
);

   import bbc_pkg::*;

   logic           in_valid_ff, in_valid_in;
   req_type        in_data_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_data_ff;
   logic           advance;
   logic           finish;
   rsp_type        result;
   chk_status_type status;

   // A byte moves on unless it is final and the output register is full.
   assign advance   = in_valid_ff &&
                      (!in_data_ff.last_symbol || !rsp_valid_ff || rsp_ready);
   assign finish    = advance && in_data_ff.last_symbol;
   assign req_ready = !in_valid_ff || advance;

   // Input register.
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   bbc_checker u_checker (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_data_ff),
      .result  (result),
      .status  (status)
   );

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The stack never holds more than its capacity.
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      status.depth <= DEPTH_W'(MAX_NESTING))
      else $error("stack depth above capacity");

   // The end of an expression leaves an empty stack and no error.
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      finish |=> (status.depth == '0) && (status.err == ERR_NONE))
      else $error("state not cleared after final byte");

   // A final byte that moves on is presented as a response next cycle.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_valid)
      else $error("final byte produced no response");

   // The balanced flag agrees with the error code.
   a_flag_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.balanced == (rsp_data.error_code == ERR_NONE)))
      else $error("balanced flag disagrees with error code");

endmodule : bracket_balance_checker_core

`default_nettype wire
